FILE: hw/rtl/kaf_pkg.sv
// Shared types, constants and helpers of the angle and gyro bias filter.
`default_nettype none

package kaf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgW  = 25;
  localparam int unsigned CfgIdxW = 2;

  // Register reset values in unsigned Q1.24
  localparam logic [CfgW-1:0] TimeStepRst   = 25'd3355443;
  localparam logic [CfgW-1:0] AngleNoiseRst = 25'd16777;
  localparam logic [CfgW-1:0] BiasNoiseRst  = 25'd50332;
  localparam logic [CfgW-1:0] MeasNoiseRst  = 25'd503316;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIME_STEP   = 2'd0,
    CFG_ANGLE_NOISE = 2'd1,
    CFG_BIAS_NOISE  = 2'd2,
    CFG_MEAS_NOISE  = 2'd3
  } cfg_idx_e;

  // Datapath step codes issued by the controller
  typedef enum logic [3:0] {
    STEP_NONE   = 4'd0,
    STEP_RATE   = 4'd1,
    STEP_APRED  = 4'd2,
    STEP_INNER  = 4'd3,
    STEP_CPRED  = 4'd4,
    STEP_P00    = 4'd5,
    STEP_DIVGO  = 4'd6,
    STEP_DIVW   = 4'd7,
    STEP_GAIN   = 4'd8,
    STEP_CORR_A = 4'd9,
    STEP_CORR_B = 4'd10,
    STEP_CORR_C = 4'd11,
    STEP_CORR_D = 4'd12,
    STEP_CORR_E = 4'd13,
    STEP_CORR_F = 4'd14,
    STEP_CORR_G = 4'd15
  } step_e;

  typedef struct packed {
    logic  load_in;
    logic  out_load;
    step_e step;
  } kaf_cmd_t;

  typedef struct packed {
    logic s_zero;
    logic div_done;
  } kaf_stat_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [DataW-1:0] sat32(input logic signed [47:0] v);
    logic signed [DataW-1:0] r;
    if (v > 48'sh0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -48'sh0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/kaf_div.sv
// Restoring divider for one gain: (num * 2^24) / den, truncated, saturated.
`default_nettype none

module kaf_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [31:0]      num_i,
  input  logic signed [33:0]      den_i,
  output logic                    done_o,
  output logic signed [31:0]      quo_o
);
  import kaf_pkg::*;

  localparam int unsigned NumW = 56;
  localparam int unsigned DenW = 34;

  logic [NumW-1:0] nq_q;
  logic [DenW-1:0] rem_q;
  logic [DenW-1:0] den_q;
  logic            neg_q;
  logic            busy_q;
  logic            done_q;
  logic [5:0]      cnt_q;

  logic [DenW:0]   shifted;
  logic signed [DenW+1:0] trial;
  logic [31:0]     num_mag;
  logic [DenW-1:0] den_mag;

  // Magnitudes of the operands
  assign num_mag = num_i[31] ? 32'(-num_i) : 32'(num_i);
  assign den_mag = den_i[33] ? 34'(-den_i) : 34'(den_i);

  // One quotient bit per cycle
  assign shifted = {rem_q, nq_q[NumW-1]};
  assign trial   = $signed({1'b0, shifted}) - $signed({2'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= {num_mag, 24'b0};
      rem_q <= '0;
      den_q <= den_mag;
      neg_q <= num_i[31] ^ den_i[33];
    end else if (busy_q) begin
      if (!trial[DenW+1]) begin
        rem_q <= trial[DenW-1:0];
        nq_q  <= {nq_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DenW-1:0];
        nq_q  <= {nq_q[NumW-2:0], 1'b0};
      end
    end
  end

  // Apply the sign and saturate
  always_comb begin
    if (!neg_q) begin
      quo_o = (nq_q > 56'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(nq_q[31:0]);
    end else begin
      quo_o = (nq_q > 56'h8000_0000) ? -32'sh8000_0000 : $signed(32'(-nq_q[31:0]));
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: hw/rtl/kaf_datapath.sv
// Datapath: filter state, registers, shared multiplier and the two gain dividers.
`default_nettype none

module kaf_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  kaf_pkg::kaf_cmd_t       cmd_i,
  output kaf_pkg::kaf_stat_t      stat_o,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [24:0]             cfg_data_i,
  input  logic signed [31:0]      measured_angle_i,
  input  logic signed [31:0]      measured_rate_i,
  output logic signed [31:0]      filtered_angle_o,
  output logic signed [31:0]      debiased_rate_o,
  output logic signed [31:0]      bias_estimate_o
);
  import kaf_pkg::*;

  typedef enum logic [1:0] {
    SH_16 = 2'd0,
    SH_24 = 2'd1,
    SH_32 = 2'd2
  } shift_e;

  // Configuration
  logic [CfgW-1:0] dt_q, qa_q, qb_q, r_q;

  // Filter state and working values
  logic signed [31:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [31:0] ma_q, mr_q, rate_q, y_q, k0_q, k1_q;
  logic signed [34:0] dp11_q;
  logic signed [35:0] inner_q;
  logic               zero_q;

  // Multiplier
  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  shift_e             sh_d, sh_q;
  logic signed [68:0] prod_q;
  logic signed [68:0] rsum;
  logic signed [47:0] rnd;

  logic signed [33:0] s_val;
  logic signed [32:0] dt_s;
  logic               div_start;
  logic               d0_done, d1_done;
  logic signed [31:0] q0, q1;

  assign dt_s  = $signed({8'b0, dt_q});
  assign s_val = 34'(p00_q) + $signed({9'b0, r_q});

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= TimeStepRst;
      qa_q <= AngleNoiseRst;
      qb_q <= BiasNoiseRst;
      r_q  <= MeasNoiseRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TIME_STEP:   dt_q <= cfg_data_i;
        CFG_ANGLE_NOISE: qa_q <= cfg_data_i;
        CFG_BIAS_NOISE:  qb_q <= cfg_data_i;
        CFG_MEAS_NOISE:  r_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Multiplier operand selection for the step being issued
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    sh_d  = SH_24;
    unique case (cmd_i.step)
      STEP_RATE:    begin mul_a = 36'(p11_q);   mul_b = dt_s; end
      STEP_APRED:   begin mul_a = 36'(rate_q);  mul_b = dt_s; sh_d = SH_16; end
      STEP_INNER:   begin mul_a = $signed({11'b0, qb_q}); mul_b = dt_s; end
      STEP_CPRED:   begin mul_a = inner_q;      mul_b = dt_s; end
      STEP_CORR_A:  begin mul_a = 36'(y_q);     mul_b = 33'(k0_q); end
      STEP_CORR_B:  begin mul_a = 36'(y_q);     mul_b = 33'(k1_q); sh_d = SH_32; end
      STEP_CORR_C:  begin mul_a = 36'(p00_q);   mul_b = 33'(k0_q); end
      STEP_CORR_D:  begin mul_a = 36'(p00_q);   mul_b = 33'(k1_q); end
      STEP_CORR_E:  begin mul_a = 36'(p01_q);   mul_b = 33'(k0_q); end
      STEP_CORR_F:  begin mul_a = 36'(p01_q);   mul_b = 33'(k1_q); end
      default: ;
    endcase
  end

  // The product is held while no step is issued, so a stalled final step keeps it.
  always_ff @(posedge clk_i) begin
    if (cmd_i.step != STEP_NONE) begin
      prod_q <= 69'(mul_a) * 69'(mul_b);
      sh_q   <= sh_d;
    end
  end

  // Round to nearest, ties upward, then shift to the target format
  always_comb begin
    rsum = prod_q;
    rnd  = '0;
    case (sh_q)
      SH_16: begin
        rsum = prod_q + 69'sd32768;
        rnd  = 48'(rsum >>> 16);
      end
      SH_32: begin
        rsum = prod_q + 69'sd2147483648;
        rnd  = 48'(rsum >>> 32);
      end
      default: begin
        rsum = prod_q + 69'sd8388608;
        rnd  = 48'(rsum >>> 24);
      end
    endcase
  end

  // State updates, one group per step that changes the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_q  <= '0;
      bias_q <= '0;
      p00_q  <= '0;
      p01_q  <= '0;
      p10_q  <= '0;
      p11_q  <= '0;
      zero_q <= 1'b0;
    end else begin
      unique case (cmd_i.step)
        STEP_INNER:  ang_q <= sat32(48'(ang_q) + rnd);
        STEP_CPRED: begin
          p11_q <= sat32(48'(p11_q) + rnd);
          p01_q <= sat32(48'(p01_q) - 48'(dp11_q));
          p10_q <= sat32(48'(p10_q) - 48'(dp11_q));
        end
        STEP_P00:    p00_q <= sat32(48'(p00_q) + rnd);
        STEP_DIVGO:  zero_q <= (s_val == '0);
        STEP_CORR_B: ang_q <= sat32(48'(ang_q) + rnd);
        STEP_CORR_C: bias_q <= sat32(48'(bias_q) + rnd);
        STEP_CORR_D: p00_q <= sat32(48'(p00_q) - rnd);
        STEP_CORR_E: p10_q <= sat32(48'(p10_q) - rnd);
        STEP_CORR_F: p01_q <= sat32(48'(p01_q) - rnd);
        STEP_CORR_G: p11_q <= sat32(48'(p11_q) - rnd);
        default: ;
      endcase
    end
  end

  // Working values that need no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ma_q <= measured_angle_i;
      mr_q <= measured_rate_i;
    end
    unique case (cmd_i.step)
      STEP_RATE:  rate_q <= sat32(48'(mr_q) - 48'(bias_q));
      STEP_APRED: dp11_q <= 35'(rnd);
      STEP_INNER: inner_q <= 36'(dp11_q) - 36'(p01_q) - 36'(p10_q) + $signed({11'b0, qa_q});
      STEP_DIVGO: y_q <= sat32(48'(ma_q) - 48'(ang_q));
      STEP_GAIN: begin
        k0_q <= zero_q ? '0 : q0;
        k1_q <= zero_q ? '0 : q1;
      end
      default: ;
    endcase
    if (cmd_i.out_load) begin
      filtered_angle_o <= ang_q;
      debiased_rate_o  <= rate_q;
      bias_estimate_o  <= bias_q;
    end
  end

  // Gain dividers run side by side
  assign div_start = (cmd_i.step == STEP_DIVGO) && (s_val != '0);

  kaf_div u_div0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (p00_q),
    .den_i   (s_val),
    .done_o  (d0_done),
    .quo_o   (q0)
  );

  kaf_div u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (p10_q),
    .den_i   (s_val),
    .done_o  (d1_done),
    .quo_o   (q1)
  );

  assign stat_o.s_zero   = (s_val == '0);
  assign stat_o.div_done = d0_done & d1_done;

endmodule

`default_nettype wire

FILE: hw/rtl/kaf_ctrl.sv
// Controller: sequences the filter steps and owns the channel handshakes.
`default_nettype none

module kaf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  kaf_pkg::kaf_stat_t  stat_i,
  output kaf_pkg::kaf_cmd_t   cmd_o
);
  import kaf_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_RATE   = 16'h0002,
    S_APRED  = 16'h0004,
    S_INNER  = 16'h0008,
    S_CPRED  = 16'h0010,
    S_P00    = 16'h0020,
    S_DIVGO  = 16'h0040,
    S_DIVW   = 16'h0080,
    S_GAIN   = 16'h0100,
    S_CORR_A = 16'h0200,
    S_CORR_B = 16'h0400,
    S_CORR_C = 16'h0800,
    S_CORR_D = 16'h1000,
    S_CORR_E = 16'h2000,
    S_CORR_F = 16'h4000,
    S_CORR_G = 16'h8000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   fin;

  // The result is loaded once the output register is free
  assign fin = (state_q == S_CORR_G) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    cmd_o.step = STEP_NONE;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_RATE;
      S_RATE:   begin cmd_o.step = STEP_RATE;   state_d = S_APRED; end
      S_APRED:  begin cmd_o.step = STEP_APRED;  state_d = S_INNER; end
      S_INNER:  begin cmd_o.step = STEP_INNER;  state_d = S_CPRED; end
      S_CPRED:  begin cmd_o.step = STEP_CPRED;  state_d = S_P00;   end
      S_P00:    begin cmd_o.step = STEP_P00;    state_d = S_DIVGO; end
      S_DIVGO: begin
        cmd_o.step = STEP_DIVGO;
        state_d = stat_i.s_zero ? S_GAIN : S_DIVW;
      end
      S_DIVW: begin
        cmd_o.step = STEP_DIVW;
        if (stat_i.div_done) state_d = S_GAIN;
      end
      S_GAIN:   begin cmd_o.step = STEP_GAIN;   state_d = S_CORR_A; end
      S_CORR_A: begin cmd_o.step = STEP_CORR_A; state_d = S_CORR_B; end
      S_CORR_B: begin cmd_o.step = STEP_CORR_B; state_d = S_CORR_C; end
      S_CORR_C: begin cmd_o.step = STEP_CORR_C; state_d = S_CORR_D; end
      S_CORR_D: begin cmd_o.step = STEP_CORR_D; state_d = S_CORR_E; end
      S_CORR_E: begin cmd_o.step = STEP_CORR_E; state_d = S_CORR_F; end
      S_CORR_F: begin cmd_o.step = STEP_CORR_F; state_d = S_CORR_G; end
      S_CORR_G: if (fin) begin
        cmd_o.step = STEP_CORR_G;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // The last covariance update and the result load share one cycle
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (fin) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign cmd_o.load_in  = in_ready_o & in_valid_i;
  assign cmd_o.out_load = fin;

endmodule

`default_nettype wire

FILE: hw/rtl/kalman_angle_filter.sv
// Top level of the two-state angle and gyro bias filter.
//
// Input channel: a beat carries a measured angle (Q8.24) and a gyro rate
// (Q16.16). Output channel: a beat carries the filtered angle, the
// debiased rate and the updated bias. Configuration: a write beat carries
// a register index (time step, angle noise, bias noise, measurement noise)
// and 25-bit data; it is always ready. The user must see that it is written
// only while idle; the block itself does not enforce this. One item is
// worked on at a time. An item takes 14 controller steps, which share one
// multiplier, plus a wait for the gain division (56 quotient bits, one per
// cycle, both gains side by side), which is skipped when the innovation
// variance is zero.
// Reset loads the default register values and clears all filter state.
// A stalled receiver keeps the result in the output register; the block
// holds the next item's final step until that register is free.
`default_nettype none

module kalman_angle_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] measured_angle_i,
  input  logic signed [31:0] measured_rate_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] filtered_angle_o,
  output logic signed [31:0] debiased_rate_o,
  output logic signed [31:0] bias_estimate_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [24:0]        cfg_data_i
);
  import kaf_pkg::*;

  kaf_cmd_t  cmd;
  kaf_stat_t stat;

  assign cfg_ready_o = 1'b1;

  kaf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  kaf_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .measured_angle_i (measured_angle_i),
    .measured_rate_i  (measured_rate_i),
    .filtered_angle_o (filtered_angle_o),
    .debiased_rate_o  (debiased_rate_o),
    .bias_estimate_o  (bias_estimate_o)
  );

  // An accepted beat closes the input until the item is finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while an item is in progress");

  // A result is never loaded over one still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten");

  // Divider completion is only seen while the controller waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.div_done |-> (cmd.step == STEP_DIVW))
    else $error("divider finished outside its wait step");

endmodule

`default_nettype wire
